>>> rtl/closest_pair_of_points_macros.svh
// ----------------------------------------------------------------------------
// Closest pair of points: assertion macros
// Concurrent assertion wrappers that fall away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef CLOSEST_PAIR_OF_POINTS_MACROS_SVH
`define CLOSEST_PAIR_OF_POINTS_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define CPOP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("closest pair assertion failed");

// The condition must never be true outside reset.
`define CPOP_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("closest pair forbidden condition seen");

`else

`define CPOP_ASSERT(label, clk, rst, prop)
`define CPOP_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

>>> rtl/cpop_pkg.sv
// ----------------------------------------------------------------------------
// Closest pair of points: package
// Sizes, sequencer state codes and the interface of the distance unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cpop_pkg;

   // Capacity of the point store and the widths that follow from it.
   localparam int MAX_POINTS = 1024;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   // Fixed field widths of the transactions.
   localparam int COORD_W    = 16;
   localparam int DIST_W     = 33;
   localparam int OUT_IDX_W  = 10;

   // Main sequencer states.
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_START,
      ST_RDI,
      ST_RDJ,
      ST_DIST,
      ST_DONE
   } cpop_state_type;

   // Phases of the shared squared distance unit.
   typedef enum logic [1:0] {
      SQ_IDLE,
      SQ_X,
      SQ_Y
   } sqd_phase_type;

   // Request to the distance unit: one pulse with both points.
   typedef struct packed {
      logic                       start;
      logic signed [COORD_W-1:0]  ax;
      logic signed [COORD_W-1:0]  ay;
      logic signed [COORD_W-1:0]  bx;
      logic signed [COORD_W-1:0]  by;
   } sqd_req_type;

   // Answer of the distance unit: one pulse with the squared distance.
   typedef struct packed {
      logic                done;
      logic [DIST_W-1:0]   dist_sq;
   } sqd_rsp_type;

endpackage

`default_nettype wire

>>> rtl/cpop_sqdist.sv
// ----------------------------------------------------------------------------
// Closest pair of points: squared distance unit
// Computes dx*dx + dy*dy with one shared 16x16 multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module cpop_sqdist (
   input  wire                    clock,
   input  wire                    reset,
   input  cpop_pkg::sqd_req_type  req,
   output cpop_pkg::sqd_rsp_type  rsp
);

   cpop_pkg::sqd_phase_type phase_ff, phase_in;
   logic                            done_ff, done_in;
   logic [cpop_pkg::COORD_W-1:0]    dx_ff, dx_in;
   logic [cpop_pkg::COORD_W-1:0]    dy_ff, dy_in;
   logic [2*cpop_pkg::COORD_W-1:0]  acc_ff, acc_in;
   logic [cpop_pkg::DIST_W-1:0]     dist_ff, dist_in;

   logic signed [cpop_pkg::COORD_W:0] diff_x, diff_y;
   logic        [cpop_pkg::COORD_W:0] mag_x, mag_y;
   logic [cpop_pkg::COORD_W-1:0]      mul_op;
   logic [2*cpop_pkg::COORD_W-1:0]    mul_prod;

   // Absolute differences; the magnitude always fits in 16 bits.
   always_comb begin
      diff_x = {req.ax[cpop_pkg::COORD_W-1], req.ax} - {req.bx[cpop_pkg::COORD_W-1], req.bx};
      diff_y = {req.ay[cpop_pkg::COORD_W-1], req.ay} - {req.by[cpop_pkg::COORD_W-1], req.by};
      mag_x  = diff_x[cpop_pkg::COORD_W] ? (cpop_pkg::COORD_W+1)'(-diff_x)
                                         : (cpop_pkg::COORD_W+1)'(diff_x);
      mag_y  = diff_y[cpop_pkg::COORD_W] ? (cpop_pkg::COORD_W+1)'(-diff_y)
                                         : (cpop_pkg::COORD_W+1)'(diff_y);
   end

   // Shared multiplier squares dx in the first phase and dy in the second.
   always_comb begin
      mul_op   = (phase_ff == cpop_pkg::SQ_X) ? dx_ff : dy_ff;
      mul_prod = mul_op * mul_op;
   end

   // Phase sequencer.
   always_comb begin
      phase_in = phase_ff;
      done_in  = 1'b0;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      acc_in   = acc_ff;
      dist_in  = dist_ff;
      case (phase_ff)
         cpop_pkg::SQ_IDLE: begin
            if (req.start) begin
               dx_in    = mag_x[cpop_pkg::COORD_W-1:0];
               dy_in    = mag_y[cpop_pkg::COORD_W-1:0];
               phase_in = cpop_pkg::SQ_X;
            end
         end
         cpop_pkg::SQ_X: begin
            acc_in   = mul_prod;
            phase_in = cpop_pkg::SQ_Y;
         end
         cpop_pkg::SQ_Y: begin
            dist_in  = {1'b0, acc_ff} + {1'b0, mul_prod};
            done_in  = 1'b1;
            phase_in = cpop_pkg::SQ_IDLE;
         end
         default: begin
            phase_in = cpop_pkg::SQ_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= cpop_pkg::SQ_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      acc_ff  <= acc_in;
      dist_ff <= dist_in;
   end

   assign rsp.done    = done_ff;
   assign rsp.dist_sq = dist_ff;

endmodule

`default_nettype wire

>>> rtl/closest_pair_of_points.sv
// Throughput: one set at a time; req_tready is low from the last point until
// the result enters the output register. The pair loop is set by one read
// port of the point store and the squared distance unit.
// Reset: clears the point count, the overflow flag and all handshake state.
// ----------------------------------------------------------------------------
// Closest pair of points: top level
// Loads points into a store, then searches all pairs in load order for the
// smallest squared distance between two distinct points.
// ----------------------------------------------------------------------------
`default_nettype none

`include "closest_pair_of_points_macros.svh"

module closest_pair_of_points (
   input  wire          clock,
   input  wire          reset,
   // Input stream
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [31:0]  req_tdata,   // point_x[15:0], point_y[31:16]
   input  wire          req_tlast,   // last_point
   // Result stream
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // min_dist_sq[32:0], first_index[42:33], second_index[52:43],
   // first_x[68:53], first_y[84:69], second_x[100:85], second_y[116:101],
   // zero padding [119:117]
   output logic [119:0] rsp_tdata,
   output logic [1:0]   rsp_tuser    // found[0], overflowed[1]
);

   localparam int CW = cpop_pkg::COORD_W;

   // Sequencer and load state.
   cpop_pkg::cpop_state_type state_ff, state_in;
   logic [cpop_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                        ovf_ff, ovf_in;
   logic [cpop_pkg::CNT_W-1:0]  i_ff, i_in;
   logic [cpop_pkg::CNT_W-1:0]  j_ff, j_in;

   // Running best pair.
   logic                          found_ff, found_in;
   logic [cpop_pkg::DIST_W-1:0]   best_ff, best_in;
   logic [cpop_pkg::IDX_W-1:0]    bi_ff, bi_in;
   logic [cpop_pkg::IDX_W-1:0]    bj_ff, bj_in;
   logic [CW-1:0]                 bxi_ff, bxi_in, byi_ff, byi_in;
   logic [CW-1:0]                 bxj_ff, bxj_in, byj_ff, byj_in;

   // Point i held while j sweeps the store.
   logic [CW-1:0]                 xi_ff, xi_in, yi_ff, yi_in;

   // Output register.
   logic                          rv_ff, rv_in;
   logic [119:0]                  rdata_ff, rdata_in;
   logic [1:0]                    ruser_ff, ruser_in;

   // Point store: y in the upper half, x in the lower half of a word.
   logic [2*CW-1:0]               mem [cpop_pkg::MAX_POINTS];
   logic [2*CW-1:0]               rd_data_ff;
   logic                          wr_en, rd_en;
   logic [cpop_pkg::IDX_W-1:0]    wr_addr, rd_addr;

   cpop_pkg::sqd_req_type         sqd_req;
   cpop_pkg::sqd_rsp_type         sqd_rsp;

   logic                          in_xact, out_xact, pair_equal;
   logic [cpop_pkg::CNT_W-1:0]    i_next, j_next;
   logic [CW-1:0]                 xj, yj;

   assign in_xact  = req_tvalid && req_tready;
   assign out_xact = rv_ff && rsp_tready;
   assign xj       = rd_data_ff[CW-1:0];
   assign yj       = rd_data_ff[2*CW-1:CW];
   assign pair_equal = (xi_ff == xj) && (yi_ff == yj);
   assign i_next   = i_ff + 1'b1;
   assign j_next   = j_ff + 1'b1;

   // Point store with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_tdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   cpop_sqdist u_sqdist (
      .clock (clock),
      .reset (reset),
      .req   (sqd_req),
      .rsp   (sqd_rsp)
   );

   // Distance request always carries point i and the last point read.
   always_comb begin
      sqd_req.start = (state_ff == cpop_pkg::ST_RDJ);
      sqd_req.ax    = xi_ff;
      sqd_req.ay    = yi_ff;
      sqd_req.bx    = xj;
      sqd_req.by    = yj;
   end

   // Sequencer: load, sweep all pairs, hand the result to the output register.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      found_in = found_ff;
      best_in  = best_ff;
      bi_in    = bi_ff;
      bj_in    = bj_ff;
      bxi_in   = bxi_ff;
      byi_in   = byi_ff;
      bxj_in   = bxj_ff;
      byj_in   = byj_ff;
      xi_in    = xi_ff;
      yi_in    = yi_ff;
      rv_in    = rv_ff && !out_xact;
      rdata_in = rdata_ff;
      ruser_in = ruser_ff;
      wr_en    = 1'b0;
      wr_addr  = count_ff[cpop_pkg::IDX_W-1:0];
      rd_en    = 1'b0;
      rd_addr  = i_ff[cpop_pkg::IDX_W-1:0];
      req_tready = (state_ff == cpop_pkg::ST_LOAD);

      case (state_ff)
         cpop_pkg::ST_LOAD: begin
            if (in_xact) begin
               if (count_ff < cpop_pkg::CNT_W'(cpop_pkg::MAX_POINTS)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  state_in = cpop_pkg::ST_START;
               end
            end
         end
         cpop_pkg::ST_START: begin
            found_in = 1'b0;
            i_in     = '0;
            if (count_ff < cpop_pkg::CNT_W'(2)) begin
               state_in = cpop_pkg::ST_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = '0;
               state_in = cpop_pkg::ST_RDI;
            end
         end
         cpop_pkg::ST_RDI: begin
            // Latch point i and fetch its first partner.
            xi_in    = xj;
            yi_in    = yj;
            j_in     = i_next;
            rd_en    = 1'b1;
            rd_addr  = i_next[cpop_pkg::IDX_W-1:0];
            state_in = cpop_pkg::ST_RDJ;
         end
         cpop_pkg::ST_RDJ: begin
            state_in = cpop_pkg::ST_DIST;
         end
         cpop_pkg::ST_DIST: begin
            if (sqd_rsp.done) begin
               // Keep the first strictly smaller distance of a distinct pair.
               if (!pair_equal && (!found_ff || (sqd_rsp.dist_sq < best_ff))) begin
                  found_in = 1'b1;
                  best_in  = sqd_rsp.dist_sq;
                  bi_in    = i_ff[cpop_pkg::IDX_W-1:0];
                  bj_in    = j_ff[cpop_pkg::IDX_W-1:0];
                  bxi_in   = xi_ff;
                  byi_in   = yi_ff;
                  bxj_in   = xj;
                  byj_in   = yj;
               end
               if (j_next < count_ff) begin
                  j_in     = j_next;
                  rd_en    = 1'b1;
                  rd_addr  = j_next[cpop_pkg::IDX_W-1:0];
                  state_in = cpop_pkg::ST_RDJ;
               end else if ((i_next + 1'b1) < count_ff) begin
                  i_in     = i_next;
                  rd_en    = 1'b1;
                  rd_addr  = i_next[cpop_pkg::IDX_W-1:0];
                  state_in = cpop_pkg::ST_RDI;
               end else begin
                  state_in = cpop_pkg::ST_DONE;
               end
            end
         end
         cpop_pkg::ST_DONE: begin
            // Move the result out once the output register is free.
            if (!rv_ff || rsp_tready) begin
               rv_in    = 1'b1;
               rdata_in = '0;
               if (found_ff) begin
                  rdata_in[32:0]    = best_ff;
                  rdata_in[42:33]   = cpop_pkg::OUT_IDX_W'(bi_ff);
                  rdata_in[52:43]   = cpop_pkg::OUT_IDX_W'(bj_ff);
                  rdata_in[68:53]   = bxi_ff;
                  rdata_in[84:69]   = byi_ff;
                  rdata_in[100:85]  = bxj_ff;
                  rdata_in[116:101] = byj_ff;
               end
               ruser_in = {ovf_ff, found_ff};
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = cpop_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = cpop_pkg::ST_LOAD;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cpop_pkg::ST_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         found_ff <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         found_ff <= found_in;
         rv_ff    <= rv_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      i_ff     <= i_in;
      j_ff     <= j_in;
      best_ff  <= best_in;
      bi_ff    <= bi_in;
      bj_ff    <= bj_in;
      bxi_ff   <= bxi_in;
      byi_ff   <= byi_in;
      bxj_ff   <= bxj_in;
      byj_ff   <= byj_in;
      xi_ff    <= xi_in;
      yi_ff    <= yi_in;
      rdata_ff <= rdata_in;
      ruser_ff <= ruser_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rdata_ff;
   assign rsp_tuser  = ruser_ff;

   // The point count never passes the store capacity.
   `CPOP_ASSERT(a_count_cap, clock, reset, count_ff <= cpop_pkg::CNT_W'(cpop_pkg::MAX_POINTS))

   // While a distance is in flight the partner index lies above point i.
   `CPOP_ASSERT(a_pair_order, clock, reset, (state_ff == cpop_pkg::ST_DIST) |-> (j_ff > i_ff))

   // The distance unit answers only while the sequencer waits for it.
   `CPOP_ASSERT(a_done_in_dist, clock, reset, sqd_rsp.done |-> (state_ff == cpop_pkg::ST_DIST))

   // A found pair reports the lower load index first.
   `CPOP_ASSERT(a_index_order, clock, reset, (rv_ff && ruser_ff[0]) |-> (rdata_ff[42:33] < rdata_ff[52:43]))

endmodule

`default_nettype wire

>>> bench/closest_pair_of_points_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Closest pair of points: testbench
// Streams point sets into the block and predicts the closest distinct pair of
// each set. Every result transaction is checked field by field against the
// oldest prediction, under random idling on both sides and one long stall.
// ----------------------------------------------------------------------------
module closest_pair_of_points_test;

   // The overflow set searches 1024 points; the limit leaves room for that
   // search several times over.
   localparam int CYCLE_LIMIT      = 8_000_000;
   localparam int DRAIN_CYCLES     = 50;
   localparam int IDLE_PERCENT     = 9;
   localparam int HOLD_OFF_CYCLES  = 3000;
   localparam int SMALL_SET_POINTS = 124;
   localparam int MAX_SHOWN        = 10;

   // How the coordinates of a random set are chosen.
   typedef enum logic [1:0] {
      SPREAD_FULL,
      SPREAD_NARROW,
      SPREAD_EDGE,
      SPREAD_SAME
   } spread_type;

   typedef struct packed {
      logic [cpop_pkg::COORD_W-1:0] x;
      logic [cpop_pkg::COORD_W-1:0] y;
      logic                         last;
   } point_type;

   typedef struct packed {
      logic [cpop_pkg::DIST_W-1:0]    dist_sq;
      logic [cpop_pkg::OUT_IDX_W-1:0] first_index;
      logic [cpop_pkg::OUT_IDX_W-1:0] second_index;
      logic [cpop_pkg::COORD_W-1:0]   first_x;
      logic [cpop_pkg::COORD_W-1:0]   first_y;
      logic [cpop_pkg::COORD_W-1:0]   second_x;
      logic [cpop_pkg::COORD_W-1:0]   second_y;
      logic                           found;
      logic                           overflowed;
   } pair_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [31:0]   req_tdata = '0;   // point_x[15:0], point_y[31:16]
   logic          req_tlast = 1'b0; // last_point
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [119:0]  rsp_tdata;        // min_dist_sq, indices, coordinates, padding
   logic [1:0]    rsp_tuser;        // found[0], overflowed[1]

   // Pending input transactions and predicted result transactions.
   point_type pending_points[$];
   pair_type  expected_pairs[$];

   // Predictor state: its own copy of the point store.
   logic [cpop_pkg::COORD_W-1:0] stored_x [cpop_pkg::MAX_POINTS];
   logic [cpop_pkg::COORD_W-1:0] stored_y [cpop_pkg::MAX_POINTS];
   int                 stored_count = 0;
   bit                 dropped_seen = 1'b0;

   int        cycle_count = 0;
   int        points_accepted = 0;
   int        results_checked = 0;
   int        mismatch_count = 0;
   int        pressure_point = 0;
   int        hold_left = 0;
   bit        hold_done = 1'b0;
   logic      req_taken = 1'b0;
   point_type next_point;
   point_type taken_point;
   pair_type  seen_pair;
   pair_type  want_pair;

   closest_pair_of_points dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Clock with a 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Store one point and, on the last point of a set, search all pairs in
   // load order. Identical points are skipped and only a strictly smaller
   // distance replaces the current best.
   task automatic load_and_search(input point_type p);
      pair_type best;
      bit       have;
      int       i;
      int       j;
      int       xi;
      int       yi;
      int       xj;
      int       yj;
      longint   dx;
      longint   dy;
      longint   d;
      if (stored_count < cpop_pkg::MAX_POINTS) begin
         stored_x[stored_count] = p.x;
         stored_y[stored_count] = p.y;
         stored_count++;
      end else begin
         dropped_seen = 1'b1;
      end
      if (p.last) begin
         best = '0;
         have = 1'b0;
         for (i = 0; i < stored_count; i++) begin
            xi = $signed(stored_x[i]);
            yi = $signed(stored_y[i]);
            for (j = i + 1; j < stored_count; j++) begin
               xj = $signed(stored_x[j]);
               yj = $signed(stored_y[j]);
               if (xi != xj || yi != yj) begin
                  dx = longint'(xi) - longint'(xj);
                  dy = longint'(yi) - longint'(yj);
                  d  = dx * dx + dy * dy;
                  if (!have || d < longint'(best.dist_sq)) begin
                     have              = 1'b1;
                     best.dist_sq      = d[cpop_pkg::DIST_W-1:0];
                     best.first_index  = i[cpop_pkg::OUT_IDX_W-1:0];
                     best.second_index = j[cpop_pkg::OUT_IDX_W-1:0];
                     best.first_x      = stored_x[i];
                     best.first_y      = stored_y[i];
                     best.second_x     = stored_x[j];
                     best.second_y     = stored_y[j];
                  end
               end
            end
         end
         best.found      = have;
         best.overflowed = dropped_seen;
         expected_pairs = {expected_pairs, best};
         stored_count = 0;
         dropped_seen = 1'b0;
      end
   endtask

   task automatic add_point(input int x, input int y, input bit last);
      point_type p;
      p.x    = x[cpop_pkg::COORD_W-1:0];
      p.y    = y[cpop_pkg::COORD_W-1:0];
      p.last = last;
      pending_points = {pending_points, p};
   endtask

   function automatic int pick_coord(input spread_type spread);
      case (spread)
         // Narrow values give many duplicates and equal distances.
         SPREAD_NARROW: pick_coord = int'($urandom_range(0, 6)) - 3;
         SPREAD_EDGE: begin
            case ($urandom_range(0, 5))
               0: pick_coord = -32768;
               1: pick_coord = -32767;
               2: pick_coord = -1;
               3: pick_coord = 0;
               4: pick_coord = 32766;
               default: pick_coord = 32767;
            endcase
         end
         default: pick_coord = int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   task automatic queue_set(input int count, input spread_type spread);
      int x;
      int y;
      int k;
      x = pick_coord(spread);
      y = pick_coord(spread);
      for (k = 0; k < count; k++) begin
         if (spread != SPREAD_SAME) begin
            x = pick_coord(spread);
            y = pick_coord(spread);
         end
         add_point(x, y, k == count - 1);
      end
   endtask

   task automatic show_pair(input string label, input pair_type p);
      $display("   %s: dist_sq %0d index %0d/%0d (%0d,%0d)-(%0d,%0d) found %0b ovf %0b",
               label, p.dist_sq, p.first_index, p.second_index,
               $signed(p.first_x), $signed(p.first_y), $signed(p.second_x),
               $signed(p.second_y), p.found, p.overflowed);
   endtask

   // The sender never idles while the accepted count is from 300 to 799, all within the overflow set.
   function automatic bit sender_idles();
      if (points_accepted >= 300 && points_accepted < 800)
         sender_idles = 1'b0;
      else
         sender_idles = $urandom_range(0, 99) < IDLE_PERCENT;
   endfunction

   // Input driver: a new point is offered once the last one was taken.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_points.size() != 0 && !sender_idles()) begin
            next_point = pending_points.pop_front();
            req_tdata  <= {next_point.y, next_point.x};
            req_tlast  <= next_point.last;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Long receiver stall once the random sets begin, so that a finished
   // result backs up and the block stops taking points.
   always @(negedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && points_accepted >= pressure_point) begin
         hold_left <= HOLD_OFF_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Result ready, with a stretch of results taken without any idling.
   always @(negedge clock) begin
      if (reset || hold_left != 0)
         rsp_tready <= 1'b0;
      else if (results_checked >= 12 && results_checked < 24)
         rsp_tready <= 1'b1;
      else
         rsp_tready <= $urandom_range(0, 99) >= IDLE_PERCENT;
   end

   // Monitor: predicts on each accepted point and checks each result.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      req_taken   <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         taken_point.x    = req_tdata[15:0];
         taken_point.y    = req_tdata[31:16];
         taken_point.last = req_tlast;
         load_and_search(taken_point);
         points_accepted <= points_accepted + 1;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_pair.dist_sq      = rsp_tdata[32:0];
         seen_pair.first_index  = rsp_tdata[42:33];
         seen_pair.second_index = rsp_tdata[52:43];
         seen_pair.first_x      = rsp_tdata[68:53];
         seen_pair.first_y      = rsp_tdata[84:69];
         seen_pair.second_x     = rsp_tdata[100:85];
         seen_pair.second_y     = rsp_tdata[116:101];
         seen_pair.found        = rsp_tuser[0];
         seen_pair.overflowed   = rsp_tuser[1];
         results_checked <= results_checked + 1;
         if (expected_pairs.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN) begin
               $display("Result with no expectation at cycle %0d", cycle_count);
               show_pair("actual", seen_pair);
            end
         end else begin
            want_pair = expected_pairs.pop_front();
            if (seen_pair !== want_pair) begin
               mismatch_count++;
               if (mismatch_count <= MAX_SHOWN) begin
                  $display("Result mismatch at cycle %0d", cycle_count);
                  show_pair("expected", want_pair);
                  show_pair("actual", seen_pair);
               end
            end
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Stimulus and end of run.
   initial begin
      // Single point, then two identical points: no distinct pair.
      add_point(0, 0, 1'b1);
      add_point(5, -5, 1'b0);
      add_point(5, -5, 1'b1);
      // Opposite corners give the largest possible distance; opposite edges follow.
      add_point(-32768, -32768, 1'b0);
      add_point(32767, 32767, 1'b1);
      add_point(32767, -32768, 1'b0);
      add_point(-32768, 32767, 1'b1);
      add_point(-32768, 0, 1'b0);
      add_point(32767, 0, 1'b1);
      // Equal distances: the first pair in load order wins.
      add_point(0, 0, 1'b0);
      add_point(1, 0, 1'b0);
      add_point(2, 0, 1'b1);
      // Duplicates are skipped while a distinct pair remains.
      add_point(7, 7, 1'b0);
      add_point(7, 7, 1'b0);
      add_point(9, 7, 1'b0);
      add_point(7, 7, 1'b1);
      // Negative coordinates with the closest pair not adjacent.
      add_point(-1, -1, 1'b0);
      add_point(100, 100, 1'b0);
      add_point(-1, 0, 1'b1);
      pressure_point = pending_points.size();

      // Small random sets of mixed spread.
      while (pending_points.size() < pressure_point + SMALL_SET_POINTS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: queue_set($urandom_range(1, 6), SPREAD_FULL);
            4, 5, 6:    queue_set($urandom_range(1, 6), SPREAD_NARROW);
            7:          queue_set($urandom_range(2, 12), SPREAD_EDGE);
            8:          queue_set($urandom_range(7, 12), SPREAD_FULL);
            default:    queue_set($urandom_range(2, 5), SPREAD_SAME);
         endcase
      end

      // A full store with the closest pair in the last two entries, then
      // three dropped points, the last of them closing the set.
      begin
         int k;
         int bx;
         int by;
         for (k = 0; k < cpop_pkg::MAX_POINTS - 2; k++)
            add_point(pick_coord(SPREAD_FULL), pick_coord(SPREAD_FULL), 1'b0);
         bx = int'($urandom_range(0, 65534)) - 32768;
         by = pick_coord(SPREAD_FULL);
         add_point(bx, by, 1'b0);
         add_point(bx + 1, by, 1'b0);
         for (k = 0; k < 3; k++)
            add_point(pick_coord(SPREAD_FULL), pick_coord(SPREAD_FULL), k == 2);
      end

      // The overflow flag and the count must start over for the next set.
      add_point(3, 4, 1'b0);
      add_point(0, 0, 1'b1);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_points.size() != 0 || req_tvalid)
         @(posedge clock);
      while (expected_pairs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
